@@ rtl/psc_pkg.sv @@
// ----------------------------------------------------------------------------
// Priority sorted conflict list: shared types and constants
// Transfer payloads, the memory request and read types, and the request codes.
// ----------------------------------------------------------------------------
package psc_pkg;

    localparam int ID_W       = 16;
    localparam int PRIO_W     = 32;
    localparam int CNT_W      = 5;
    localparam int MAX_ADDR_W = 6;

    localparam logic KIND_PUSH   = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef struct packed {
        logic                     kind;
        logic [ID_W-1:0]          node_id;
        logic signed [PRIO_W-1:0] priority_req;
    } t_in_item;

    typedef struct packed {
        logic                     front_valid;
        logic [ID_W-1:0]          front_id;
        logic signed [PRIO_W-1:0] front_priority;
        logic [CNT_W-1:0]         front_ties;
        logic [CNT_W-1:0]         entry_count;
        logic                     dropped_full;
        logic                     was_duplicate;
        logic                     was_absent;
    } t_out_item;

    typedef struct packed {
        logic                     we;
        logic [MAX_ADDR_W-1:0]    wr_addr;
        logic [MAX_ADDR_W-1:0]    rd_addr;
        logic [ID_W-1:0]          wr_id;
        logic signed [PRIO_W-1:0] wr_prio;
    } t_mem_req;

    typedef struct packed {
        logic [ID_W-1:0]          id;
        logic signed [PRIO_W-1:0] prio;
    } t_mem_rd;

endpackage

@@ rtl/psc_store.sv @@
// ----------------------------------------------------------------------------
// Priority sorted conflict list: entry store
// Single write port, single registered read port memory for identifiers and
// priorities.
// ----------------------------------------------------------------------------
module psc_store #(
    parameter int DEPTH = 16,
    parameter int IDW   = 16
) (
    input  logic              i_clk,
    input  psc_pkg::t_mem_req i_req,
    output psc_pkg::t_mem_rd  o_rd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [IDW-1:0]                    r_mem_id [DEPTH];
    logic signed [psc_pkg::PRIO_W-1:0] r_mem_pr [DEPTH];
    psc_pkg::t_mem_rd                  r_rd;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem_id[i_req.wr_addr[AW-1:0]] <= i_req.wr_id[IDW-1:0];
            r_mem_pr[i_req.wr_addr[AW-1:0]] <= i_req.wr_prio;
        end
        r_rd.id   <= psc_pkg::ID_W'(r_mem_id[i_req.rd_addr[AW-1:0]]);
        r_rd.prio <= r_mem_pr[i_req.rd_addr[AW-1:0]];
    end

    assign o_rd = r_rd;

endmodule

@@ rtl/psc_ctrl.sv @@
// ----------------------------------------------------------------------------
// Priority sorted conflict list: sequencer
// Scans the store, shifts entries to insert or
// remove, then walks the head run to build the result.
// ----------------------------------------------------------------------------
module psc_ctrl #(
    parameter int DEPTH = 16,
    parameter int IDW   = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  psc_pkg::t_in_item  i_item,
    input  logic               i_slot_free,
    output logic               o_done,
    output psc_pkg::t_out_item o_result,
    output psc_pkg::t_mem_req  o_req,
    input  psc_pkg::t_mem_rd   i_rd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_CMP,
        S_DECIDE,
        S_INS,
        S_INS_WR,
        S_DEL,
        S_DEL_WR,
        S_TIES,
        S_TIES_CMP,
        S_DONE
    } t_state;

    t_state                            r_state;
    logic                              r_kind;
    logic [psc_pkg::ID_W-1:0]          r_id;
    logic signed [psc_pkg::PRIO_W-1:0] r_prio;
    logic [CW-1:0]                     r_i;
    logic [CW-1:0]                     r_count;
    logic                              r_found;
    logic [CW-1:0]                     r_pos;
    logic                              r_at_found;
    logic [CW-1:0]                     r_at;
    logic                              r_dup;
    logic                              r_drop;
    logic                              r_absent;
    logic [psc_pkg::ID_W-1:0]          r_front_id;
    logic signed [psc_pkg::PRIO_W-1:0] r_front_prio;
    logic [CW-1:0]                     r_ties;

    function automatic logic [psc_pkg::MAX_ADDR_W-1:0] to_addr(input logic [CW-1:0] v);
        return psc_pkg::MAX_ADDR_W'(v[AW-1:0]);
    endfunction

    always_comb begin
        o_req = '0;
        unique case (r_state)
            S_SCAN, S_TIES: begin
                o_req.rd_addr = to_addr(r_i);
            end
            S_INS: begin
                if (r_i == r_at) begin
                    o_req.we      = 1'b1;
                    o_req.wr_addr = to_addr(r_at);
                    o_req.wr_id   = r_id;
                    o_req.wr_prio = r_prio;
                end else begin
                    o_req.rd_addr = to_addr(CW'(r_i - 1'b1));
                end
            end
            S_DEL: begin
                o_req.rd_addr = to_addr(CW'(r_i + 1'b1));
            end
            S_INS_WR, S_DEL_WR: begin
                o_req.we      = 1'b1;
                o_req.wr_addr = to_addr(r_i);
                o_req.wr_id   = i_rd.id;
                o_req.wr_prio = i_rd.prio;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_kind     <= i_item.kind;
                        r_id       <= psc_pkg::ID_W'(i_item.node_id[IDW-1:0]);
                        r_prio     <= i_item.priority_req;
                        r_i        <= '0;
                        r_found    <= 1'b0;
                        r_pos      <= '0;
                        r_at_found <= 1'b0;
                        r_at       <= r_count;
                        r_dup      <= 1'b0;
                        r_drop     <= 1'b0;
                        r_absent   <= 1'b0;
                        r_state    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_state <= (r_i == r_count) ? S_DECIDE : S_SCAN_CMP;
                end
                S_SCAN_CMP: begin
                    if (!r_found && i_rd.id == r_id) begin
                        r_found <= 1'b1;
                        r_pos   <= r_i;
                    end
                    if (!r_at_found && r_prio < i_rd.prio) begin
                        r_at_found <= 1'b1;
                        r_at       <= r_i;
                    end
                    r_i     <= CW'(r_i + 1'b1);
                    r_state <= S_SCAN;
                end
                S_DECIDE: begin
                    r_ties       <= '0;
                    r_front_id   <= '0;
                    r_front_prio <= '0;
                    r_dup        <= (r_kind == psc_pkg::KIND_PUSH) && r_found;
                    r_drop       <= (r_kind == psc_pkg::KIND_PUSH) && !r_found &&
                                    (r_count == CW'(DEPTH));
                    r_absent     <= (r_kind == psc_pkg::KIND_REMOVE) && !r_found;
                    if (r_kind == psc_pkg::KIND_PUSH && !r_found &&
                        r_count != CW'(DEPTH)) begin
                        r_i     <= r_count;
                        r_state <= S_INS;
                    end else if (r_kind == psc_pkg::KIND_REMOVE && r_found) begin
                        r_i     <= r_pos;
                        r_state <= S_DEL;
                    end else begin
                        r_i     <= '0;
                        r_state <= S_TIES;
                    end
                end
                S_INS: begin
                    if (r_i == r_at) begin
                        r_count <= CW'(r_count + 1'b1);
                        r_i     <= '0;
                        r_state <= S_TIES;
                    end else begin
                        r_state <= S_INS_WR;
                    end
                end
                S_INS_WR: begin
                    r_i     <= CW'(r_i - 1'b1);
                    r_state <= S_INS;
                end
                S_DEL: begin
                    if (r_i == CW'(r_count - 1'b1)) begin
                        r_count <= CW'(r_count - 1'b1);
                        r_i     <= '0;
                        r_state <= S_TIES;
                    end else begin
                        r_state <= S_DEL_WR;
                    end
                end
                S_DEL_WR: begin
                    r_i     <= CW'(r_i + 1'b1);
                    r_state <= S_DEL;
                end
                S_TIES: begin
                    r_state <= (r_i == r_count) ? S_DONE : S_TIES_CMP;
                end
                S_TIES_CMP: begin
                    if (r_i == '0) begin
                        r_front_id   <= i_rd.id;
                        r_front_prio <= i_rd.prio;
                        r_ties       <= CW'(1);
                        r_i          <= CW'(1);
                        r_state      <= S_TIES;
                    end else if (i_rd.prio == r_front_prio) begin
                        r_ties  <= CW'(r_ties + 1'b1);
                        r_i     <= CW'(r_i + 1'b1);
                        r_state <= S_TIES;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_done  = (r_state == S_DONE) && i_slot_free;

    always_comb begin
        o_result                = '0;
        o_result.front_valid    = (r_count != '0);
        o_result.front_id       = r_front_id;
        o_result.front_priority = r_front_prio;
        o_result.front_ties     = psc_pkg::CNT_W'(r_ties);
        o_result.entry_count    = psc_pkg::CNT_W'(r_count);
        o_result.dropped_full   = r_drop;
        o_result.was_duplicate  = r_dup;
        o_result.was_absent     = r_absent;
    end

endmodule

@@ rtl/priority_sorted_conflict_list_unit.sv @@
// ----------------------------------------------------------------------------
// Priority sorted conflict list unit
// Ordered list of requester identifiers by signed priority with duplicate
// suppression, one result transfer per request transfer.
// ----------------------------------------------------------------------------
// Each request is taken in, then the N held entries are scanned and a decision
// is made, then the M entries behind the insertion or removal point are shifted
// (none for a duplicate, a full store or an absent entry), then the T leading
// entries that share the head priority are walked, and the result is handed
// to the output register; every step goes through the single read and single
// write port of the entry store. The input is ready only while the sequencer
// is idle, but it is ready again while the previous result still waits in the
// output register; the sequencer holds in its last step while that register
// still holds a result that has not been taken.
module priority_sorted_conflict_list_unit #(
    parameter int DEPTH        = 16,
    parameter int NODE_ID_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  psc_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output psc_pkg::t_out_item o_result
);

    localparam int IDW = (NODE_ID_BITS < psc_pkg::ID_W) ? NODE_ID_BITS : psc_pkg::ID_W;

    psc_pkg::t_mem_req  mem_req;
    psc_pkg::t_mem_rd   mem_rd;
    psc_pkg::t_out_item result;
    logic               done;
    logic               slot_free;
    logic               r_out_valid;
    psc_pkg::t_out_item r_out;

    assign slot_free = !r_out_valid || i_ready;

    psc_ctrl #(
        .DEPTH (DEPTH),
        .IDW   (IDW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .i_slot_free (slot_free),
        .o_done      (done),
        .o_result    (result),
        .o_req       (mem_req),
        .i_rd        (mem_rd)
    );

    psc_store #(
        .DEPTH (DEPTH),
        .IDW   (IDW)
    ) u_store (
        .i_clk (i_clk),
        .i_req (mem_req),
        .o_rd  (mem_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out <= result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

@@ rtl/psc_checker.sv @@
// ----------------------------------------------------------------------------
// Priority sorted conflict list: port checker
// Concurrent checks on the ports of the top level, attached by bind.
// ----------------------------------------------------------------------------
module psc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input psc_pkg::t_in_item  i_item,
    input logic               o_valid,
    input logic               i_ready,
    input psc_pkg::t_out_item o_result
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result))
        else $error("Result changed or vanished before its transfer.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("Request accepted again before the previous one was done.");

    a_empty_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.front_valid |->
            o_result.front_id == '0 && o_result.front_priority == '0 &&
            o_result.front_ties == '0)
        else $error("Empty list reported a non-zero head.");

    a_one_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $countones({o_result.dropped_full, o_result.was_duplicate,
                                o_result.was_absent}) <= 1)
        else $error("More than one status flag raised on one result.");

endmodule

bind priority_sorted_conflict_list_unit psc_checker u_psc_checker (.*);
